[sv/rhtb_pkg.sv]
// Shared types, constants and character helpers for the hex text decoder.
`default_nettype none
package rhtb_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [6:0] MAX_BYTES_RST = 7'd16;

  localparam logic CMD_CHAR    = 1'b0;
  localparam logic CMD_END     = 1'b1;
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_ODD      = 2'd3
  } status_t;

  typedef struct packed {
    logic       nh;
    logic [3:0] hn;
    logic       zd;
    logic [6:0] bd;
    status_t    fe;
  } dec_t;

  typedef struct packed {
    dec_t       s;
    logic       hv;
    logic [7:0] dat;
    logic [6:0] idx;
  } tk_t;

  typedef struct packed {
    logic       has_data;
    logic [7:0] data;
    logic [6:0] idx;
    logic       has_status;
    status_t    status;
    logic [6:0] count;
  } op_t;

  // Bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 8'(c - CH_ZERO);
      return {1'b0, d[3:0]};
    end
    if (c >= CH_LA && c <= CH_LF) begin
      d = 8'(c - CH_LA + 8'd10);
      return {1'b0, d[3:0]};
    end
    if (c >= CH_UA && c <= CH_UF) begin
      d = 8'(c - CH_UA + 8'd10);
      return {1'b0, d[3:0]};
    end
    return 5'h10;
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL ||
           c == CH_COMMA || c == CH_COLON || c == CH_UNDER || c == CH_DASH;
  endfunction

endpackage
`default_nettype wire

[sv/relaxed_hex_text_to_bytes.sv]
// The word that causes a result is written into the queue; the output stage then registers it onto out_valid.
// Throughput: one input word per cycle while the queue is not full; the queue absorbs output stalls.
// An end of text whose held zero completes a byte yields two results: the data byte, then the status.
// Reset is synchronous and active low: the queue empties, text state clears,
// and the byte limit returns to 16.
`default_nettype none
module relaxed_hex_text_to_bytes (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_ch,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_kind,
  output logic [7:0]      out_data_byte,
  output logic [1:0]      out_status,
  output logic [6:0]      out_byte_count,
  output logic            out_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [6:0] cfg_data
);
  import rhtb_pkg::*;

  logic q_full;
  logic q_push;
  op_t  q_op;
  logic q_pop;
  logic q_empty;
  op_t  q_head;

  rhtb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_ch     (in_ch),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (q_op)
  );

  rhtb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_op),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head_op (q_head)
  );

  rhtb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_status     (out_status),
    .out_byte_count (out_byte_count),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

[sv/rhtb_front.sv]
// Front end: accepts characters, classifies them and pairs nibbles into queue words.
`default_nettype none
module rhtb_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          in_cmd,
  input  wire logic [7:0]    in_ch,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [6:0]    cfg_data,
  input  wire logic          q_full,
  output logic               q_push,
  output rhtb_pkg::op_t      q_op
);
  import rhtb_pkg::*;

  dec_t       dec_r, dec_nxt;
  logic [6:0] max_bytes_r, max_bytes_nxt;
  logic       acc;
  logic       produce;

  function automatic tk_t take_digit(input dec_t s, input logic [3:0] nib,
                                     input logic [6:0] mx);
    tk_t r;
    r.s   = s;
    r.hv  = 1'b0;
    r.dat = 8'd0;
    r.idx = 7'd0;
    if (!s.nh) begin
      r.s.hn = nib;
      r.s.nh = 1'b1;
    end else begin
      r.s.nh = 1'b0;
      if (s.bd >= mx) begin
        r.s.fe = ST_OVERFLOW;
      end else begin
        r.hv   = 1'b1;
        r.dat  = {s.hn, nib};
        r.idx  = s.bd;
        r.s.bd = 7'(s.bd + 7'd1);
      end
    end
    return r;
  endfunction

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && !in_stall;

  always_comb begin
    tk_t        t;
    dec_t       cur;
    logic       hv;
    logic [7:0] dat;
    logic [6:0] idx;
    logic       done;
    logic [4:0] dv;
    t    = '0;
    cur  = dec_r;
    hv   = 1'b0;
    dat  = 8'd0;
    idx  = 7'd0;
    done = 1'b0;
    dv   = digit_value(in_ch);
    q_op = '0;
    if (in_cmd == CMD_END) begin
      if (cur.fe == ST_OK && cur.zd) begin
        t   = take_digit(cur, 4'd0, max_bytes_r);
        cur = t.s;
        hv  = t.hv;
        dat = t.dat;
        idx = t.idx;
      end
      if (cur.fe == ST_OK && cur.nh) begin
        cur.fe = ST_ODD;
      end
      q_op.has_status = 1'b1;
      q_op.status     = cur.fe;
      q_op.count      = (cur.fe == ST_OK) ? cur.bd : 7'd0;
      cur             = '0;
    end else if (cur.fe == ST_OK) begin
      if (cur.zd) begin
        cur.zd = 1'b0;
        if (in_ch == CH_LX || in_ch == CH_UX) begin
          done = 1'b1;
        end else begin
          t    = take_digit(cur, 4'd0, max_bytes_r);
          cur  = t.s;
          hv   = t.hv;
          dat  = t.dat;
          idx  = t.idx;
          done = (cur.fe != ST_OK);
        end
      end
      if (!done) begin
        if (in_ch == CH_ZERO) begin
          cur.zd = 1'b1;
        end else if (is_separator(in_ch)) begin
          cur.zd = 1'b0;
        end else if (dv[4]) begin
          cur.fe = ST_BAD_CHAR;
        end else begin
          t   = take_digit(cur, dv[3:0], max_bytes_r);
          cur = t.s;
          if (t.hv) begin
            hv  = 1'b1;
            dat = t.dat;
            idx = t.idx;
          end
        end
      end
    end
    q_op.has_data = hv;
    q_op.data     = dat;
    q_op.idx      = idx;
    dec_nxt       = acc ? cur : dec_r;
    produce       = hv || (in_cmd == CMD_END);
    max_bytes_nxt = (cfg_valid && cfg_ready) ? cfg_data : max_bytes_r;
  end

  assign q_push = acc && produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r       <= '0;
      max_bytes_r <= MAX_BYTES_RST;
    end else begin
      dec_r       <= dec_nxt;
      max_bytes_r <= max_bytes_nxt;
    end
  end

`ifndef SYNTH
  a_err_no_zero: assert property (@(posedge clk) disable iff (!rst_n)
    dec_r.fe != ST_OK |-> !dec_r.zd)
    else $error("held zero kept after an error");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_cmd == CMD_END) |=> (dec_r.bd == 7'd0 && !dec_r.nh && dec_r.fe == ST_OK))
    else $error("text state not cleared at end of text");
`endif
endmodule
`default_nettype wire

[sv/rhtb_queue.sv]
// Short queue of decoded words between the front end and the output stage.
`default_nettype none
module rhtb_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rhtb_pkg::op_t push_op,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output rhtb_pkg::op_t      head_op
);
  import rhtb_pkg::*;

  op_t              mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt;
  logic [QAW-1:0]   rp_r, rp_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             do_pop;

  assign full    = (cnt_r == QCW'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head_op = mem_r[rp_r];
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = push ? QAW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop ? QAW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = QCW'(cnt_r + QCW'(push) - QCW'(do_pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_op;
    end
  end

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("queue fill count out of range");
`endif
endmodule
`default_nettype wire

[sv/rhtb_back.sv]
// Output stage: turns queue words into data and status results.
`default_nettype none
module rhtb_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire rhtb_pkg::op_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               out_kind,
  output logic [7:0]         out_data_byte,
  output logic [1:0]         out_status,
  output logic [6:0]         out_byte_count,
  output logic               out_last
);
  import rhtb_pkg::*;

  logic       valid_r, valid_nxt;
  logic       pend_r, pend_nxt;
  status_t    pst_r, pst_nxt;
  logic [6:0] pcnt_r, pcnt_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] data_r, data_nxt;
  status_t    st_r, st_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       last_r, last_nxt;
  logic       free;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    pend_nxt  = pend_r;
    pst_nxt   = pst_r;
    pcnt_nxt  = pcnt_r;
    kind_nxt  = kind_r;
    data_nxt  = data_r;
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (free) begin
      if (pend_r) begin
        valid_nxt = 1'b1;
        pend_nxt  = 1'b0;
        kind_nxt  = KIND_STATUS;
        data_nxt  = 8'd0;
        st_nxt    = pst_r;
        cnt_nxt   = pcnt_r;
        last_nxt  = 1'b1;
      end else if (!q_empty) begin
        q_pop     = 1'b1;
        valid_nxt = 1'b1;
        if (q_head.has_data) begin
          kind_nxt = KIND_DATA;
          data_nxt = q_head.data;
          st_nxt   = ST_OK;
          cnt_nxt  = q_head.idx;
          last_nxt = 1'b0;
          pend_nxt = q_head.has_status;
          pst_nxt  = q_head.status;
          pcnt_nxt = q_head.count;
        end else begin
          kind_nxt = KIND_STATUS;
          data_nxt = 8'd0;
          st_nxt   = q_head.status;
          cnt_nxt  = q_head.count;
          last_nxt = 1'b1;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pst_r  <= pst_nxt;
    pcnt_r <= pcnt_nxt;
    kind_r <= kind_nxt;
    data_r <= data_nxt;
    st_r   <= st_nxt;
    cnt_r  <= cnt_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_data_byte  = data_r;
  assign out_status     = st_r;
  assign out_byte_count = cnt_r;
  assign out_last       = last_r;

`ifndef SYNTH
  a_pend_shown: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (valid_r && kind_r == KIND_DATA))
    else $error("pending status without a data word on the output");
`endif
endmodule
`default_nettype wire
